[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Each macro samples on i_clk and is quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lru_pr_pkg.sv]
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared constants and types of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 16;

    localparam int CFG_BITS   = 5;
    localparam int FAULT_BITS = 32;

    localparam logic [CFG_BITS-1:0]   FRAME_COUNT_RST = 5'd4;
    localparam logic [FAULT_BITS-1:0] FAULT_MAX       = 32'hFFFF_FFFF;

    // Outcome of one lookup in the frame table
    typedef struct packed {
        logic fault;
        logic evict;
    } t_lookup_res;

endpackage

[hw/rtl/lru_page_replacement.sv]
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement unit: one page reference in, one hit/fault result out.
// ----------------------------------------------------------------------------
// The block accepts one page reference per clock while the result side does
// not stall, and returns one result per reference: hit or fault, the evicted
// page on a replacement, and the running saturating fault total. The
// accepting edge loads the input register; the tag compare and recency
// update over all frames then run combinationally and load the result
// register when it is free or drains. The frame table lookup and the rank
// update of all frames happen in that one combinational path, which is what
// sets the clock rate. The input side keeps accepting while a result waits,
// as long as the result register will free up in the same cycle.
// i_cfg_frame_count selects how many frames take part (0 acts as 1, values
// above MAX_FRAMES act as MAX_FRAMES); write it only while no transaction is
// in flight.
module lru_page_replacement import lru_pr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_BITS-1:0]   i_cfg_frame_count,
    // page reference channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_page_fault,
    output logic                  o_evicted_valid,
    output logic [PAGE_BITS-1:0]  o_evicted_page,
    output logic [FAULT_BITS-1:0] o_fault_total
);

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);

    logic [CFG_BITS-1:0]   r_frame_count;
    logic                  r_in_valid;
    logic [PAGE_BITS-1:0]  r_in_page;
    logic [FAULT_BITS-1:0] r_fault_total;
    logic [FAULT_BITS-1:0] n_fault_total;

    logic                  r_out_valid;
    logic                  r_out_fault;
    logic                  r_out_evict;
    logic [PAGE_BITS-1:0]  r_out_ev_page;
    logic [FAULT_BITS-1:0] r_out_total;

    logic                  fire;
    logic [31:0]           cfg_ext;
    logic [CNT_W-1:0]      active_count;
    t_lookup_res           lookup;
    logic [PAGE_BITS-1:0]  ev_page;

    // Advance the stored reference when the result register is free or drains
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // Clamp the configured frame count into 1..MAX_FRAMES
    assign cfg_ext = 32'(r_frame_count);
    always_comb begin
        if (cfg_ext == 32'd0) begin
            active_count = CNT_W'(1);
        end else if (cfg_ext > 32'(MAX_FRAMES)) begin
            active_count = CNT_W'(MAX_FRAMES);
        end else begin
            active_count = CNT_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_frame_count;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_page <= i_page_number;
        end
    end

    lru_pr_frame_table #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_frame_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_update       (fire),
        .i_page         (r_in_page),
        .i_active_count (active_count),
        .o_res          (lookup),
        .o_evicted_page (ev_page)
    );

    // Saturating fault total, counting this reference
    assign n_fault_total = (lookup.fault && (r_fault_total != FAULT_MAX))
                         ? r_fault_total + FAULT_BITS'(1) : r_fault_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault_total <= '0;
        end else if (fire) begin
            r_fault_total <= n_fault_total;
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_fault   <= lookup.fault;
            r_out_evict   <= lookup.evict;
            r_out_ev_page <= ev_page;
            r_out_total   <= n_fault_total;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_page_fault    = r_out_fault;
    assign o_evicted_valid = r_out_evict;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_total;

endmodule

[hw/rtl/lru_pr_frame_table.sv]
// ----------------------------------------------------------------------------
// lru_pr_frame_table
// Fully associative frame store with recency ranks: lookup and update
// of one page reference per cycle; the update is taken only when i_update is set.
// ----------------------------------------------------------------------------
module lru_pr_frame_table import lru_pr_pkg::*; #(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    localparam int CNT_W     = $clog2(MAX_FRAMES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [CNT_W-1:0]     i_active_count,
    output t_lookup_res          o_res,
    output logic [PAGE_BITS-1:0] o_evicted_page
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [PAGE_BITS-1:0] r_page [MAX_FRAMES];
    logic [RANK_W-1:0]    r_rank [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;

    logic [PAGE_BITS-1:0] n_page [MAX_FRAMES];
    logic [RANK_W-1:0]    n_rank [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] n_valid;

    logic [MAX_FRAMES-1:0] live;
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] empty;
    logic [MAX_FRAMES-1:0] lru_cand;
    logic [MAX_FRAMES-1:0] match_oh;
    logic [MAX_FRAMES-1:0] empty_oh;
    logic [MAX_FRAMES-1:0] lru_oh;
    logic [MAX_FRAMES-1:0] touch_oh;
    logic                  hit;
    logic                  fill;
    logic                  evict;
    logic [RANK_W-1:0]     touch_rank;
    logic [PAGE_BITS-1:0]  ev_page;

    // Classify frames: active and valid, tag match, empty slot
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            live[i]  = (CNT_W'(i) < i_active_count) && r_valid[i];
            match[i] = live[i] && (r_page[i] == i_page);
            empty[i] = (CNT_W'(i) < i_active_count) && !r_valid[i];
        end
    end

    // LRU frame: highest rank among live frames, lowest index on a tie
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            lru_cand[i] = live[i];
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (j < i && live[j] && !(r_rank[j] < r_rank[i])) begin
                    lru_cand[i] = 1'b0;
                end
                if (j > i && live[j] && (r_rank[j] > r_rank[i])) begin
                    lru_cand[i] = 1'b0;
                end
            end
        end
    end

    assign match_oh = match & (~match + MAX_FRAMES'(1));
    assign empty_oh = empty & (~empty + MAX_FRAMES'(1));
    assign lru_oh   = lru_cand & (~lru_cand + MAX_FRAMES'(1));

    assign hit   = |match;
    assign fill  = !hit && (|empty);
    assign evict = !hit && !(|empty);

    assign touch_oh = hit ? match_oh : (evict ? lru_oh : '0);

    always_comb begin
        touch_rank = '0;
        ev_page    = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            touch_rank = touch_rank | (touch_oh[i] ? r_rank[i] : '0);
            ev_page    = ev_page | ((evict && lru_oh[i]) ? r_page[i] : '0);
        end
    end

    assign o_res.fault    = !hit;
    assign o_res.evict    = evict;
    assign o_evicted_page = ev_page;

    // Next state: a fill ages every valid frame; a hit or a replacement ages
    // only the frames more recent than the touched one.
    always_comb begin
        n_valid = r_valid;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_page[i] = r_page[i];
            n_rank[i] = r_rank[i];
            if (fill) begin
                if (empty_oh[i]) begin
                    n_valid[i] = 1'b1;
                    n_page[i]  = i_page;
                    n_rank[i]  = '0;
                end else if (r_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else if (touch_oh[i]) begin
                n_rank[i] = '0;
                if (evict) begin
                    n_page[i] = i_page;
                end
            end else if (r_valid[i] && (r_rank[i] < touch_rank)) begin
                n_rank[i] = r_rank[i] + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_update) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_update) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_page[i] <= n_page[i];
                r_rank[i] <= n_rank[i];
            end
        end
    end

endmodule

[hw/rtl/lru_pr_checker.sv]
// ----------------------------------------------------------------------------
// lru_pr_checker
// Port-level checks of the LRU page replacement unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_pr_checker #(
    parameter int PAGE_BITS = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_page_fault,
    input logic                 o_evicted_valid,
    input logic [PAGE_BITS-1:0] o_evicted_page,
    input logic [31:0]          o_fault_total
);

    logic in_xact;
    logic out_xact;

    assign in_xact  = i_in_valid && o_in_ready;
    assign out_xact = o_out_valid && i_out_ready;

    // A pending result holds until taken
    `ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_fault_total), "result dropped or changed while stalled")

    // With no replacement shown, a nonzero evicted page while a reference is accepted must come with a fault
    `ASSERT_IMPL(a_evict_fault, o_out_valid && !o_evicted_valid, !in_xact || (o_evicted_page == '0) || o_page_fault, "evicted page shown without replacement")

    // Back-to-back results: a fault advances the total by one until saturation
    `ASSERT_IMPL(a_total_step, out_xact ##1 (o_out_valid && o_page_fault && ($past(o_fault_total) != 32'hFFFF_FFFF)), o_fault_total == $past(o_fault_total) + 32'd1, "fault total did not advance on a fault")

    // Back-to-back results: a hit leaves the total alone and shows no eviction
    `ASSERT_IMPL(a_total_hold, out_xact ##1 (o_out_valid && !o_page_fault), (o_fault_total == $past(o_fault_total)) && !o_evicted_valid, "fault total changed on a hit")

endmodule

bind lru_page_replacement lru_pr_checker #(.PAGE_BITS(PAGE_BITS)) u_checker (.*);
